>>> design/point_offset_along_normal_top_defines.svh
// Assertion macros for the point offset block and its checker.
`ifndef POINT_OFFSET_ALONG_NORMAL_TOP_DEFINES_SVH
`define POINT_OFFSET_ALONG_NORMAL_TOP_DEFINES_SVH

// The antecedent and the consequent hold in the same cycle.
`define PON_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PON_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/pon_pkg.sv
// Package with the widths, types and constants of the point offset block.
`timescale 1ns / 1ps
`default_nettype none
package pon_pkg;

   localparam int CW        = 32;             // coordinate width
   localparam int NW        = 16;             // normal component width
   localparam int NF        = NW - 4;         // normal fraction bits
   localparam int SUM_W     = 2 * NW;         // sum of squares
   localparam int SQ_SHIFT  = 48 - 2 * NF;
   localparam int XW        = SUM_W + SQ_SHIFT;
   localparam int ROOT_W    = XW / 2;
   localparam int UNIT_Q24  = 1 << 24;
   localparam int KEEP_TOL  = 1677;
   localparam int KEEP_LO   = UNIT_Q24 - KEEP_TOL;
   localparam int KEEP_HI   = UNIT_Q24 + KEEP_TOL;
   localparam int DIV_SHIFT = 48 - NF;
   localparam int DVW       = NW + DIV_SHIFT; // dividend width
   localparam int QW        = NW + 24;        // quotient width
   localparam int UW        = QW + 1;         // signed unit normal, Q.24
   localparam int U_KEEP_SH = 24 - NF;
   localparam int UL_W      = 24;
   localparam int UH_W      = UW - UL_W;
   localparam int PL_W      = UL_W + 1 + CW;
   localparam int PH_W      = UH_W + CW;
   localparam int TW        = UH_W + CW + UL_W + 1;
   localparam int OFF_W     = TW - UL_W;
   localparam int V_W       = OFF_W + 1;
   localparam int HALF_Q24  = 1 << 23;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_POINT,
      ST_BAD_NORMAL,
      ST_BAD_DIST
   } status_type;

   typedef struct packed {
      logic [2:0][CW-1:0] pnt;
      logic [CW-1:0]      offset;
      logic [2:0][NW-1:0] nrm;
      logic               point_ok;
      logic               normal_nan;
      logic               dist_nan;
      logic               s_zero;
      logic               keep;
      status_type         status;
   } item_type;

endpackage
`default_nettype wire

>>> design/pon_if.sv
// Request and response channel interfaces of the point offset block.
`timescale 1ns / 1ps
`default_nettype none
interface pon_req_if;
   logic                          valid;
   logic                          ready;
   logic signed [pon_pkg::CW-1:0] point_x;
   logic signed [pon_pkg::CW-1:0] point_y;
   logic signed [pon_pkg::CW-1:0] point_z;
   logic                          point_ok;
   logic signed [pon_pkg::NW-1:0] normal_x;
   logic signed [pon_pkg::NW-1:0] normal_y;
   logic signed [pon_pkg::NW-1:0] normal_z;
   logic                          normal_nan;
   logic signed [pon_pkg::CW-1:0] offset_dist;
   logic                          dist_nan;

   modport source (output valid, point_x, point_y, point_z, point_ok, normal_x, normal_y,
                   normal_z, normal_nan, offset_dist, dist_nan, input ready);
   modport sink (input valid, point_x, point_y, point_z, point_ok, normal_x, normal_y,
                 normal_z, normal_nan, offset_dist, dist_nan, output ready);
endinterface

interface pon_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic signed [pon_pkg::CW-1:0] out_x;
   logic signed [pon_pkg::CW-1:0] out_y;
   logic signed [pon_pkg::CW-1:0] out_z;

   modport source (output valid, status, out_x, out_y, out_z, input ready);
   modport sink (input valid, status, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

>>> design/point_offset_along_normal_top.sv
// The pipeline takes one beat per cycle while the response is not stalled; the 28-step root pipeline and the 40-step
// divider pipeline each retire one bit per stage, so every stage holds one beat.
// A stalled response holds the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module point_offset_along_normal_top (
   input  wire logic clock,
   input  wire logic reset,
   pon_req_if.sink   req_bus,
   pon_rsp_if.source rsp_bus
);

   logic adv;
   logic rsp_valid_ff;

   // Input stage: capture the beat and square the normal components.
   pon_pkg::item_type                        in_item_ff, in_item_in;
   logic [2:0][pon_pkg::SUM_W-1:0]           sq_ff, sq_in;
   logic                                     in_vld_ff;

   // Square root pipeline, index 0 holds the sum of squares.
   pon_pkg::item_type      sr_item_ff [pon_pkg::ROOT_W+1];
   logic [pon_pkg::XW:0]   sr_rem_ff  [pon_pkg::ROOT_W+1];
   logic [pon_pkg::ROOT_W-1:0] sr_root_ff [pon_pkg::ROOT_W+1];
   logic                   sr_vld_ff  [pon_pkg::ROOT_W+1];
   logic [pon_pkg::SUM_W-1:0] sum_in;
   pon_pkg::item_type      sr_item_in;

   // Divider pipeline, index 0 holds the normalized dividends.
   pon_pkg::item_type                   dv_item_ff [pon_pkg::QW+1];
   logic [pon_pkg::ROOT_W-1:0]          dv_root_ff [pon_pkg::QW+1];
   logic [2:0][pon_pkg::ROOT_W-1:0]     dv_rem_ff  [pon_pkg::QW+1];
   logic [2:0][pon_pkg::NW-1:0]         dv_mag_ff  [pon_pkg::QW+1];
   logic [2:0][pon_pkg::QW-1:0]         dv_quo_ff  [pon_pkg::QW+1];
   logic                                dv_vld_ff  [pon_pkg::QW+1];
   pon_pkg::item_type                   dv_item_in;
   logic [2:0][pon_pkg::ROOT_W-1:0]     dv_rem_in;
   logic [2:0][pon_pkg::NW-1:0]         dv_mag_in;

   // Unit normal, partial products, rounded offset.
   pon_pkg::item_type              uu_item_ff, ml_item_ff, sm_item_ff;
   logic                           uu_vld_ff, ml_vld_ff, sm_vld_ff;
   logic signed [pon_pkg::UW-1:0]    uu_ff [3], uu_in [3];
   logic signed [pon_pkg::PL_W-1:0]  pl_ff [3], pl_in [3];
   logic signed [pon_pkg::PH_W-1:0]  ph_ff [3], ph_in [3];
   logic signed [pon_pkg::OFF_W-1:0] off_ff [3], off_in [3];

   // Response register.
   pon_pkg::status_type             status_ff;
   logic signed [pon_pkg::CW-1:0]   out_ff [3], out_in [3];

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // ---------------- input stage ----------------
   always_comb begin
      in_item_in            = '0;
      in_item_in.pnt[0]     = req_bus.point_x;
      in_item_in.pnt[1]     = req_bus.point_y;
      in_item_in.pnt[2]     = req_bus.point_z;
      in_item_in.offset     = req_bus.offset_dist;
      in_item_in.nrm[0]     = req_bus.normal_x;
      in_item_in.nrm[1]     = req_bus.normal_y;
      in_item_in.nrm[2]     = req_bus.normal_z;
      in_item_in.point_ok   = req_bus.point_ok;
      in_item_in.normal_nan = req_bus.normal_nan;
      in_item_in.dist_nan   = req_bus.dist_nan;
      in_item_in.status     = pon_pkg::ST_OK;
      sq_in[0] = $unsigned(pon_pkg::SUM_W'(req_bus.normal_x)
                           * pon_pkg::SUM_W'(req_bus.normal_x));
      sq_in[1] = $unsigned(pon_pkg::SUM_W'(req_bus.normal_y)
                           * pon_pkg::SUM_W'(req_bus.normal_y));
      sq_in[2] = $unsigned(pon_pkg::SUM_W'(req_bus.normal_z)
                           * pon_pkg::SUM_W'(req_bus.normal_z));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_item_ff <= in_item_in;
         sq_ff      <= sq_in;
      end
   end

   // ---------------- sum of squares ----------------
   assign sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   always_comb begin
      sr_item_in        = in_item_ff;
      sr_item_in.s_zero = (sum_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         sr_vld_ff[0] <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sr_item_ff[0]        <= sr_item_in;
         sr_rem_ff[0]         <= (pon_pkg::XW+1)'({sum_in, {pon_pkg::SQ_SHIFT{1'b0}}});
         sr_root_ff[0]        <= '0;
      end
   end

   // ---------------- square root, one result bit per stage ----------------
   for (genvar k = 0; k < pon_pkg::ROOT_W; k++) begin : g_sqrt
      logic [pon_pkg::XW:0] test;
      logic                 take;

      // Trial value is (2*root + bit) * bit for the bit under test.
      always_comb begin
         test = ((pon_pkg::XW+1)'(sr_root_ff[k]) << (pon_pkg::ROOT_W - k))
                | ((pon_pkg::XW+1)'(1) << (2 * (pon_pkg::ROOT_W - 1 - k)));
         take = (sr_rem_ff[k] >= test);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sr_vld_ff[k+1] <= sr_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sr_item_ff[k+1] <= sr_item_ff[k];
            sr_rem_ff[k+1]  <= take ? (sr_rem_ff[k] - test) : sr_rem_ff[k];
            sr_root_ff[k+1] <= take ?
               (sr_root_ff[k] | (pon_pkg::ROOT_W'(1) << (pon_pkg::ROOT_W - 1 - k))) :
               sr_root_ff[k];
         end
      end
   end

   // ---------------- status and divider entry ----------------
   always_comb begin
      logic [pon_pkg::DVW-1:0] dvd0;
      logic [pon_pkg::ROOT_W-1:0] root;
      dvd0       = '0;
      root       = sr_root_ff[pon_pkg::ROOT_W];
      dv_item_in = sr_item_ff[pon_pkg::ROOT_W];
      dv_item_in.keep = (root >= pon_pkg::ROOT_W'(pon_pkg::KEEP_LO)) &&
                        (root <= pon_pkg::ROOT_W'(pon_pkg::KEEP_HI));
      // Priority: point, then normal, then distance.
      if (!dv_item_in.point_ok) begin
         dv_item_in.status = pon_pkg::ST_BAD_POINT;
      end else if (dv_item_in.normal_nan) begin
         dv_item_in.status = pon_pkg::ST_BAD_NORMAL;
      end else if (!dv_item_in.keep && dv_item_in.s_zero) begin
         dv_item_in.status = pon_pkg::ST_BAD_NORMAL;
      end else if (dv_item_in.dist_nan) begin
         dv_item_in.status = pon_pkg::ST_BAD_DIST;
      end else begin
         dv_item_in.status = pon_pkg::ST_OK;
      end
      for (int c = 0; c < 3; c++) begin
         dv_mag_in[c] = dv_item_in.nrm[c][pon_pkg::NW-1] ?
                        (pon_pkg::NW'(0) - dv_item_in.nrm[c]) : dv_item_in.nrm[c];
         dvd0         = {dv_mag_in[c], {pon_pkg::DIV_SHIFT{1'b0}}};
         // The top dividend bits lie below the root whenever the normal is nonzero.
         dv_rem_in[c] = pon_pkg::ROOT_W'(dvd0[pon_pkg::DVW-1:pon_pkg::QW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= sr_vld_ff[pon_pkg::ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_item_ff[0] <= dv_item_in;
         dv_root_ff[0] <= sr_root_ff[pon_pkg::ROOT_W];
         dv_rem_ff[0]  <= dv_rem_in;
         dv_mag_ff[0]  <= dv_mag_in;
         dv_quo_ff[0]  <= '0;
      end
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   for (genvar k = 0; k < pon_pkg::QW; k++) begin : g_div
      logic [pon_pkg::DVW-1:0]      dvd   [3];
      logic [pon_pkg::ROOT_W:0]     trial [3];
      logic                         take  [3];
      logic [2:0][pon_pkg::ROOT_W-1:0] rem_in;
      logic [2:0][pon_pkg::QW-1:0]     quo_in;

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            dvd[c]   = {dv_mag_ff[k][c], {pon_pkg::DIV_SHIFT{1'b0}}};
            trial[c] = {dv_rem_ff[k][c], dvd[c][pon_pkg::QW-1-k]};
            take[c]  = (trial[c] >= {1'b0, dv_root_ff[k]});
            rem_in[c] = take[c] ?
                        pon_pkg::ROOT_W'(trial[c] - {1'b0, dv_root_ff[k]}) :
                        trial[c][pon_pkg::ROOT_W-1:0];
            quo_in[c] = {dv_quo_ff[k][c][pon_pkg::QW-2:0], take[c]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_item_ff[k+1] <= dv_item_ff[k];
            dv_root_ff[k+1] <= dv_root_ff[k];
            dv_mag_ff[k+1]  <= dv_mag_ff[k];
            dv_rem_ff[k+1]  <= rem_in;
            dv_quo_ff[k+1]  <= quo_in;
         end
      end
   end

   // ---------------- unit normal in Q.24 ----------------
   always_comb begin
      logic signed [pon_pkg::UW-1:0] q;
      q = '0;
      for (int c = 0; c < 3; c++) begin
         if (dv_item_ff[pon_pkg::QW].keep) begin
            uu_in[c] = pon_pkg::UW'($signed(dv_item_ff[pon_pkg::QW].nrm[c]))
                       <<< pon_pkg::U_KEEP_SH;
         end else begin
            q        = {1'b0, dv_quo_ff[pon_pkg::QW][c]};
            uu_in[c] = dv_item_ff[pon_pkg::QW].nrm[c][pon_pkg::NW-1] ? -q : q;
         end
      end
   end

   // ---------------- partial products of u and distance ----------------
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pl_in[c] = $signed({1'b0, uu_ff[c][pon_pkg::UL_W-1:0]})
                    * $signed(uu_item_ff.offset);
         ph_in[c] = $signed(uu_ff[c][pon_pkg::UW-1:pon_pkg::UL_W])
                    * $signed(uu_item_ff.offset);
      end
   end

   // ---------------- recombine and round to nearest, ties up ----------------
   always_comb begin
      logic signed [pon_pkg::TW-1:0] t;
      t = '0;
      for (int c = 0; c < 3; c++) begin
         t = (pon_pkg::TW'(ph_ff[c]) <<< pon_pkg::UL_W) + pon_pkg::TW'(pl_ff[c])
             + pon_pkg::TW'(pon_pkg::HALF_Q24);
         off_in[c] = t[pon_pkg::TW-1:pon_pkg::UL_W];
      end
   end

   // ---------------- add to the point and saturate, zero on error ----------------
   always_comb begin
      logic signed [pon_pkg::V_W-1:0] v;
      logic [pon_pkg::V_W-pon_pkg::CW:0] top;
      v   = '0;
      top = '0;
      for (int c = 0; c < 3; c++) begin
         v   = pon_pkg::V_W'($signed(sm_item_ff.pnt[c])) + pon_pkg::V_W'(off_ff[c]);
         top = v[pon_pkg::V_W-1:pon_pkg::CW-1];
         if (sm_item_ff.status != pon_pkg::ST_OK) begin
            out_in[c] = '0;
         end else if ((&top) || !(|top)) begin
            out_in[c] = v[pon_pkg::CW-1:0];
         end else if (top[pon_pkg::V_W-pon_pkg::CW]) begin
            out_in[c] = {1'b1, {(pon_pkg::CW-1){1'b0}}};
         end else begin
            out_in[c] = {1'b0, {(pon_pkg::CW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uu_vld_ff    <= 1'b0;
         ml_vld_ff    <= 1'b0;
         sm_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         uu_vld_ff    <= dv_vld_ff[pon_pkg::QW];
         ml_vld_ff    <= uu_vld_ff;
         sm_vld_ff    <= ml_vld_ff;
         rsp_valid_ff <= sm_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         uu_item_ff <= dv_item_ff[pon_pkg::QW];
         ml_item_ff <= uu_item_ff;
         sm_item_ff <= ml_item_ff;
         status_ff  <= sm_item_ff.status;
         for (int c = 0; c < 3; c++) begin
            uu_ff[c]  <= uu_in[c];
            pl_ff[c]  <= pl_in[c];
            ph_ff[c]  <= ph_in[c];
            off_ff[c] <= off_in[c];
            out_ff[c] <= out_in[c];
         end
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = status_ff;
   assign rsp_bus.out_x  = out_ff[0];
   assign rsp_bus.out_y  = out_ff[1];
   assign rsp_bus.out_z  = out_ff[2];

endmodule
`default_nettype wire

>>> design/pon_checker.sv
// Port checker for the point offset block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "point_offset_along_normal_top_defines.svh"
module pon_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [1:0]            rsp_status,
   input wire logic [pon_pkg::CW-1:0] rsp_out_x,
   input wire logic [pon_pkg::CW-1:0] rsp_out_y,
   input wire logic [pon_pkg::CW-1:0] rsp_out_z
);

   // A beat held back by the sink keeps its content.
   `PON_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z), "response changed while stalled")

   // An error result carries zero coordinates.
   `PON_ASSERT_IMP(a_err_zero, rsp_valid && rsp_status != pon_pkg::ST_OK, rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0, "error result with nonzero coordinates")

   // With the response register empty the pipeline always takes a beat.
   `PON_ASSERT_IMP(a_ready_free, !rsp_valid, req_ready, "not ready with empty output")

   // A stalled response freezes the whole pipeline.
   `PON_ASSERT_IMP(a_ready_stall, rsp_valid && !rsp_ready, !req_ready, "ready while output stalled")

endmodule

bind point_offset_along_normal_top pon_checker u_pon_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_out_x  (rsp_bus.out_x),
   .rsp_out_y  (rsp_bus.out_y),
   .rsp_out_z  (rsp_bus.out_z)
);
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the point offset block: random and directed beats checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import pon_pkg::*;

   typedef struct {
      logic signed [CW-1:0] px, py, pz;
      logic                 pok;
      logic signed [NW-1:0] nx, ny, nz;
      logic                 nnan;
      logic signed [CW-1:0] offset;
      logic                 dnan;
   } beat_type;

   typedef struct {
      status_type           status;
      logic signed [CW-1:0] x, y, z;
   } moved_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   pon_req_if req_bus ();
   pon_rsp_if rsp_bus ();

   point_offset_along_normal_top dut (.clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus));

   beat_type  pending_beats[$];
   moved_type expected_points[$];
   int     send_idle_pct = 12;
   int     recv_idle_pct = 50;
   int     hold_cycles   = 0;
   int     errors        = 0;
   int     checked       = 0;
   int     cycle_count   = 0;
   int     error_results = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned floor_root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // round(u * d / 2^24), ties toward +infinity; 128-bit math avoids overflow.
   function automatic longint scaled_offset(longint u, longint d);
      logic signed [127:0] t;
      t = 128'(signed'(u)) * 128'(signed'(d)) + 128'sd8388608;
      return longint'(t >>> 24);
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi[CW-1:0];
      if (v < lo) return lo[CW-1:0];
      return v[CW-1:0];
   endfunction

   function automatic moved_type offset_point(beat_type b);
      moved_type m;
      longint n[3], p[3], u[3];
      longint unsigned s, r, mag;
      longint diff;
      n[0] = b.nx; n[1] = b.ny; n[2] = b.nz;
      p[0] = b.px; p[1] = b.py; p[2] = b.pz;
      s = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
      r = floor_root(s << (48 - 2 * NF));
      m.status = ST_OK;
      if (!b.pok) begin
         m.status = ST_BAD_POINT;
      end else if (b.nnan) begin
         m.status = ST_BAD_NORMAL;
      end else begin
         diff = longint'(r) - UNIT_Q24;
         if (diff >= -KEEP_TOL && diff <= KEEP_TOL) begin
            for (int i = 0; i < 3; i++) u[i] = n[i] * (64'sd1 <<< (24 - NF));
         end else if (s == 0) begin
            m.status = ST_BAD_NORMAL;
         end else begin
            for (int i = 0; i < 3; i++) begin
               mag = n[i] < 0 ? -n[i] : n[i];
               u[i] = longint'((mag << (48 - NF)) / r);
               if (n[i] < 0) u[i] = -u[i];
            end
         end
         if (m.status == ST_OK && b.dnan) m.status = ST_BAD_DIST;
      end
      m.x = 0; m.y = 0; m.z = 0;
      if (m.status == ST_OK) begin
         m.x = clamp_coord(p[0] + scaled_offset(u[0], b.offset));
         m.y = clamp_coord(p[1] + scaled_offset(u[1], b.offset));
         m.z = clamp_coord(p[2] + scaled_offset(u[2], b.offset));
      end
      return m;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return {1'b0, {(CW-1){1'b1}}};
         1: return {1'b1, {(CW-1){1'b0}}};
         2: return CW'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic beat_type random_beat();
      beat_type b;
      logic signed [NW-1:0] unit;
      b.px = rand_coord(); b.py = rand_coord(); b.pz = rand_coord();
      b.offset = rand_coord();
      b.pok  = ($urandom_range(0, 9) != 0);
      b.nnan = ($urandom_range(0, 14) == 0);
      b.dnan = ($urandom_range(0, 14) == 0);
      unit = NW'(1 << NF);
      case ($urandom_range(0, 4))
         // Axis unit normals land on the kept path.
         0: begin
            b.nx = '0; b.ny = '0; b.nz = '0;
            case ($urandom_range(0, 2))
               0: b.nx = $urandom_range(0, 1) ? unit : -unit;
               1: b.ny = $urandom_range(0, 1) ? unit : -unit;
               default: b.nz = $urandom_range(0, 1) ? unit : -unit;
            endcase
         end
         1: begin
            b.nx = NW'($signed($urandom_range(0, 8)) - 4);
            b.ny = NW'($signed($urandom_range(0, 8)) - 4);
            b.nz = NW'($signed($urandom_range(0, 8)) - 4);
         end
         default: begin
            b.nx = NW'($urandom); b.ny = NW'($urandom); b.nz = NW'($urandom);
         end
      endcase
      return b;
   endfunction

   function automatic beat_type make_beat(logic signed [CW-1:0] p, logic signed [NW-1:0] nx,
                                          logic signed [NW-1:0] ny, logic signed [NW-1:0] nz,
                                          logic signed [CW-1:0] d, logic pok, logic nnan,
                                          logic dnan);
      beat_type b;
      b.px = p; b.py = -p; b.pz = p ^ 32'h5a5a_0000;
      b.nx = nx; b.ny = ny; b.nz = nz;
      b.offset = d; b.pok = pok; b.nnan = nnan; b.dnan = dnan;
      return b;
   endfunction

   // Driver: one nonblocking update of valid per edge.
   always @(posedge clock) begin
      beat_type b;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) void'(pending_beats.pop_front());
         if ((!req_bus.valid || req_bus.ready) || !req_bus.valid) begin
            if (pending_beats.size() > (req_bus.valid && req_bus.ready ? 0 : 0)
                && pending_beats.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct) begin
               b = pending_beats[0];
               req_bus.valid       <= 1'b1;
               req_bus.point_x     <= b.px;
               req_bus.point_y     <= b.py;
               req_bus.point_z     <= b.pz;
               req_bus.point_ok    <= b.pok;
               req_bus.normal_x    <= b.nx;
               req_bus.normal_y    <= b.ny;
               req_bus.normal_z    <= b.nz;
               req_bus.normal_nan  <= b.nnan;
               req_bus.offset_dist <= b.offset;
               req_bus.dist_nan    <= b.dnan;
               expected_points.push_back(offset_point(b));
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness, with a long hold-off requested by the stimulus.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles   <= hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: compare each accepted response beat with the oldest expectation.
   always @(posedge clock) begin
      moved_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_points.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            e = expected_points.pop_front();
            checked++;
            if (e.status != ST_OK) error_results++;
            if (rsp_bus.status !== e.status) begin
               $error("status expected %0d got %0d", e.status, rsp_bus.status);
               errors++;
            end
            if (rsp_bus.out_x !== e.x) begin
               $error("out_x expected %0d got %0d", e.x, rsp_bus.out_x);
               errors++;
            end
            if (rsp_bus.out_y !== e.y) begin
               $error("out_y expected %0d got %0d", e.y, rsp_bus.out_y);
               errors++;
            end
            if (rsp_bus.out_z !== e.z) begin
               $error("out_z expected %0d got %0d", e.z, rsp_bus.out_z);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic drain();
      while (pending_beats.size() != 0 || req_bus.valid) @(posedge clock);
   endtask

   initial begin
      logic signed [CW-1:0] cmax, cmin;
      logic signed [NW-1:0] unit;
      req_bus.valid = 1'b0;
      req_bus.point_x = 0; req_bus.point_y = 0; req_bus.point_z = 0;
      req_bus.point_ok = 0; req_bus.normal_x = 0; req_bus.normal_y = 0;
      req_bus.normal_z = 0; req_bus.normal_nan = 0; req_bus.offset_dist = 0;
      req_bus.dist_nan = 0;
      rsp_bus.ready = 1'b0;
      cmax = {1'b0, {(CW-1){1'b1}}};
      cmin = {1'b1, {(CW-1){1'b0}}};
      unit = NW'(1 << NF);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: flags and their priority, zero and kept normals, extremes.
      pending_beats.push_back(make_beat(32'sh10000, unit, '0, '0, 32'sh20000,
                                        1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(32'sh10000, '0, -unit, '0, -32'sh30000,
                                        1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(32'sh10000, 16'sd1, 16'sd1, 16'sd1, 32'sh10000,
                                        1'b0, 1'b1, 1'b1));
      pending_beats.push_back(make_beat(32'sh10000, 16'sd1, 16'sd1, 16'sd1, 32'sh10000,
                                        1'b1, 1'b1, 1'b1));
      pending_beats.push_back(make_beat(32'sh10000, 16'sd1, 16'sd1, 16'sd1, 32'sh10000,
                                        1'b1, 1'b0, 1'b1));
      pending_beats.push_back(make_beat(32'sh10000, '0, '0, '0, 32'sh10000,
                                        1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(32'sh10000, '0, '0, '0, 32'sh10000,
                                        1'b1, 1'b0, 1'b1));
      pending_beats.push_back(make_beat(cmax, unit, unit, unit, cmax, 1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(cmin, -unit, -unit, -unit, cmax,
                                        1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(cmax, unit + 16'sd1, '0, '0, cmax,
                                        1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(cmin, 16'sh7fff, 16'sh7fff, 16'sh7fff, cmin,
                                        1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(cmin, -16'sh8000, -16'sh8000, -16'sh8000, cmax,
                                        1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(32'sd0, 16'sd1, '0, '0, -32'sd1,
                                        1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(32'sd0, -16'sd1, '0, '0, 32'sd1,
                                        1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(-32'sd1, 16'sd3, 16'sd4, '0, 32'sh8000,
                                        1'b1, 1'b0, 1'b0));
      pending_beats.push_back(make_beat(32'sh1234, unit, '0, '0, 32'sh80,
                                        1'b1, 1'b0, 1'b0));
      for (int i = 0; i < 500; i++) pending_beats.push_back(random_beat());
      drain();

      // Hold the receiver off long enough for the pipeline to fill.
      send_idle_pct = 0;
      hold_cycles   = 300;
      for (int i = 0; i < 150; i++) pending_beats.push_back(random_beat());
      drain();

      send_idle_pct = 50;
      recv_idle_pct = 12;
      for (int i = 0; i < 450; i++) pending_beats.push_back(random_beat());
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 450; i++) pending_beats.push_back(random_beat());
      drain();

      while (expected_points.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Checked %0d response beats, %0d of them with an error status.",
               checked, error_results);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
+incdir+design
design/pon_pkg.sv
design/pon_if.sv
design/point_offset_along_normal_top.sv
design/pon_checker.sv
tb/tb_top.sv
